[rtl/bfeu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bfeu_pkg;

    // Sizes of the stores
    localparam int TAPE_CELLS  = 32768;
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_BITS   = 16;

    localparam int TAPE_AW = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;
    localparam int STK_AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STK_CW  = $clog2(STACK_DEPTH + 1);
    localparam int SKIP_W  = 7;
    localparam logic [SKIP_W-1:0] SKIP_MAX = 7'd127;

    localparam logic [7:0] CELL_MAX_RST = 8'd127;

    // Program characters that act
    localparam logic [7:0] CMD_LEFT  = 8'h3C; // <
    localparam logic [7:0] CMD_RIGHT = 8'h3E; // >
    localparam logic [7:0] CMD_PLUS  = 8'h2B; // +
    localparam logic [7:0] CMD_MINUS = 8'h2D; // -
    localparam logic [7:0] CMD_DOT   = 8'h2E; // .
    localparam logic [7:0] CMD_COMMA = 8'h2C; // ,
    localparam logic [7:0] CMD_OPEN  = 8'h5B; // [
    localparam logic [7:0] CMD_CLOSE = 8'h5D; // ]

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2
    } bfeu_err_t;

    typedef struct packed {
        logic [7:0]           cmd;
        logic [ADDR_BITS-1:0] addr;
        logic signed [31:0]   in_value;
    } bfeu_in_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] next_addr;
        logic                 jumped;
        logic                 out_valid;
        logic [7:0]           out_char;
        logic                 skipping;
        logic [1:0]           error;
    } bfeu_out_t;

endpackage
`default_nettype wire

[rtl/bfeu_outbuf.sv]
`timescale 1ns / 1ps
`default_nettype none
module bfeu_outbuf (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire bfeu_pkg::bfeu_out_t in_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bfeu_pkg::bfeu_out_t      m_data
);
    import bfeu_pkg::*;

    logic      out_valid_reg;
    logic      skid_valid_reg;
    bfeu_out_t out_reg;
    bfeu_out_t skid_reg;
    logic      m_fire;
    logic      in_fire;

    assign m_fire   = out_valid_reg & m_ready;
    assign in_ready = ~skid_valid_reg;
    assign in_fire  = in_valid & in_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    // Hold the control flags of the two slots
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_fire) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_fire) begin
            if (!out_valid_reg || m_fire) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Move words through the output and skid slots
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_fire) begin
                out_reg <= skid_reg;
            end
        end else if (in_fire) begin
            if (!out_valid_reg || m_fire) begin
                out_reg <= in_data;
            end else begin
                skid_reg <= in_data;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/brainfuck_execution_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Results are registered in the output slot, or the skid slot when it is full.
// Throughput: one word per cycle while s_ready is high; the current cell and
// stack top come from registered memory reads of the next pointer, with write
// forwarding. Reset: control state clears at once, then a pass zeroes all 32768
// cells, one cell a cycle, with s_ready low; cfg writes are taken always.
module brainfuck_execution_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire bfeu_pkg::bfeu_in_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output bfeu_pkg::bfeu_out_t     m_data
);
    import bfeu_pkg::*;

    // Memories
    logic [7:0]           tape_mem [TAPE_CELLS];
    logic [ADDR_BITS-1:0] stack_mem [STACK_DEPTH];

    // Control and state registers
    logic [7:0]         cell_max_reg;
    logic [TAPE_AW-1:0] ptr_reg, ptr_next;
    logic [STK_CW-1:0]  cnt_reg, cnt_next;
    logic [SKIP_W-1:0]  skip_reg, skip_next;
    logic               clr_busy_reg;
    logic [TAPE_AW-1:0] clr_addr_reg;

    // Registered read data
    logic [7:0]           cell_rd_reg;
    logic [ADDR_BITS-1:0] top_rd_reg;

    // Step logic
    logic                 buf_ready;
    logic                 accept;
    logic                 tape_we;
    logic [TAPE_AW-1:0]   tape_waddr;
    logic [7:0]           tape_wdata;
    logic [7:0]           cell_new;
    logic                 cell_wr;
    logic                 push;
    logic [STK_AW-1:0]    stk_raddr;
    logic [7:0]           clamp_val;
    bfeu_out_t            res;

    assign cfg_ready = 1'b1;
    assign s_ready   = buf_ready & ~clr_busy_reg;
    assign accept    = s_valid & s_ready;

    // Clamp the comma value into 0..cell_max
    always_comb begin
        if (s_data.in_value[31]) begin
            clamp_val = 8'd0;
        end else if (s_data.in_value > $signed({24'd0, cell_max_reg})) begin
            clamp_val = cell_max_reg;
        end else begin
            clamp_val = s_data.in_value[7:0];
        end
    end

    // Execute one character against the current cell and stack top
    always_comb begin
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        skip_next     = skip_reg;
        cell_new      = cell_rd_reg;
        cell_wr       = 1'b0;
        push          = 1'b0;
        res.next_addr = s_data.addr + ADDR_BITS'(1);
        res.jumped    = 1'b0;
        res.out_valid = 1'b0;
        res.out_char  = 8'd0;
        res.error     = ERR_NONE;
        if (accept) begin
            if (skip_reg != '0) begin
                if (s_data.cmd == CMD_OPEN) begin
                    if (skip_reg < SKIP_MAX) begin
                        skip_next = skip_reg + SKIP_W'(1);
                    end
                end else if (s_data.cmd == CMD_CLOSE) begin
                    skip_next = skip_reg - SKIP_W'(1);
                end
            end else begin
                case (s_data.cmd)
                    CMD_LEFT: begin
                        ptr_next = (ptr_reg == '0) ? TAPE_AW'(TAPE_CELLS - 1)
                                                   : ptr_reg - TAPE_AW'(1);
                    end
                    CMD_RIGHT: begin
                        ptr_next = (ptr_reg >= TAPE_AW'(TAPE_CELLS - 1)) ? '0
                                                   : ptr_reg + TAPE_AW'(1);
                    end
                    CMD_PLUS: begin
                        cell_wr  = 1'b1;
                        cell_new = (cell_rd_reg >= cell_max_reg) ? 8'd0
                                                                 : cell_rd_reg + 8'd1;
                    end
                    CMD_MINUS: begin
                        cell_wr  = 1'b1;
                        cell_new = (cell_rd_reg == 8'd0) ? cell_max_reg
                                                         : cell_rd_reg - 8'd1;
                    end
                    CMD_DOT: begin
                        res.out_valid = 1'b1;
                        res.out_char  = cell_rd_reg;
                    end
                    CMD_COMMA: begin
                        cell_wr  = 1'b1;
                        cell_new = clamp_val;
                    end
                    CMD_OPEN: begin
                        if (cell_rd_reg == 8'd0) begin
                            skip_next = SKIP_W'(1);
                        end else if (cnt_reg >= STK_CW'(STACK_DEPTH)) begin
                            res.error = ERR_OVERFLOW;
                        end else begin
                            push     = 1'b1;
                            cnt_next = cnt_reg + STK_CW'(1);
                        end
                    end
                    CMD_CLOSE: begin
                        if (cnt_reg == '0) begin
                            res.error = ERR_UNDERFLOW;
                        end else if (cell_rd_reg == 8'd0) begin
                            cnt_next = cnt_reg - STK_CW'(1);
                        end else begin
                            res.next_addr = top_rd_reg + ADDR_BITS'(1);
                            res.jumped    = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        res.skipping = (skip_next != '0);
    end

    // Select the tape write: clearing pass or cell update
    always_comb begin
        tape_we    = clr_busy_reg | cell_wr;
        tape_waddr = clr_busy_reg ? clr_addr_reg : ptr_reg;
        tape_wdata = clr_busy_reg ? 8'd0 : cell_new;
    end

    // Tape: write the current cell, read the next one, forward a same-cell write
    always_ff @(posedge aclk) begin
        if (tape_we) begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        if (tape_we && (tape_waddr == ptr_next)) begin
            cell_rd_reg <= tape_wdata;
        end else begin
            cell_rd_reg <= tape_mem[ptr_next];
        end
    end

    // Loop stack: push at the count, read the new top, forward a push
    assign stk_raddr = STK_AW'(cnt_next - STK_CW'(1));

    always_ff @(posedge aclk) begin
        if (push) begin
            stack_mem[cnt_reg[STK_AW-1:0]] <= s_data.addr;
        end
        if (push) begin
            top_rd_reg <= s_data.addr;
        end else begin
            top_rd_reg <= stack_mem[stk_raddr];
        end
    end

    // Advance pointer, stack count, skip depth and the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg      <= '0;
            cnt_reg      <= '0;
            skip_reg     <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            ptr_reg  <= ptr_next;
            cnt_reg  <= cnt_next;
            skip_reg <= skip_next;
            if (clr_busy_reg) begin
                if (clr_addr_reg == TAPE_AW'(TAPE_CELLS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + TAPE_AW'(1);
            end
        end
    end

    // Take the cell limit from the configuration word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_max_reg <= CELL_MAX_RST;
        end else if (cfg_valid && cfg_ready) begin
            cell_max_reg <= cfg_data;
        end
    end

    bfeu_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (accept),
        .in_ready (buf_ready),
        .in_data  (res),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

[sim/brainfuck_execution_unit_tb.sv]
`timescale 1ns / 1ps
module brainfuck_execution_unit_tb;
    import bfeu_pkg::*;

    // Index of the live copy of the machine state and of the planning copy
    localparam int LIVE = 0;
    localparam int PLAN = 1;
    localparam int REPORT_CAP = 40;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    bfeu_in_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    bfeu_out_t  m_data;

    brainfuck_execution_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Machine state: the live copy follows accepted words, the planning copy
    // runs ahead over queued words so that programs can follow their own jumps
    bit [7:0]           tape_img  [2][TAPE_CELLS];
    bit [TAPE_AW-1:0]   ptr_img   [2];
    bit [ADDR_BITS-1:0] stack_img [2][STACK_DEPTH];
    int unsigned        nest_img  [2];
    int unsigned        skip_img  [2];
    bit [7:0]           cell_max_img = CELL_MAX_RST;

    bfeu_in_t   program_words [$];
    bfeu_out_t  due_results [$];
    logic [7:0] prog_text [$];
    bfeu_in_t   next_word;

    bit calm = 1'b0;
    int send_gap = 0;
    int hold_left = 0;
    int words_queued = 0;
    int results_seen = 0;
    int fail_count = 0;
    int cfg_writes = 0;
    int jumps_seen = 0;
    int dots_seen = 0;
    int skips_seen = 0;
    int overflows_seen = 0;
    int underflows_seen = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Execute one program character on copy s and return the result word
    function automatic bfeu_out_t execute_char(input int s, input bfeu_in_t w);
        bfeu_out_t        r;
        bit [7:0]         cell_val;
        bit [TAPE_AW-1:0] p;
        bfeu_err_t        err;
        p = ptr_img[s];
        cell_val = tape_img[s][p];
        err = ERR_NONE;
        r = '0;
        r.next_addr = w.addr + ADDR_BITS'(1);
        if (skip_img[s] != 0) begin
            // skipping: only brackets move the depth, which saturates
            if (w.cmd == CMD_OPEN) begin
                if (skip_img[s] < SKIP_MAX) skip_img[s]++;
            end else if (w.cmd == CMD_CLOSE) begin
                skip_img[s]--;
            end
        end else begin
            case (w.cmd)
                CMD_LEFT: begin
                    ptr_img[s] = (p == 0) ? TAPE_AW'(TAPE_CELLS - 1) : p - TAPE_AW'(1);
                end
                CMD_RIGHT: begin
                    ptr_img[s] = (p >= TAPE_CELLS - 1) ? '0 : p + TAPE_AW'(1);
                end
                CMD_PLUS: begin
                    tape_img[s][p] = (cell_val >= cell_max_img) ? 8'd0 : cell_val + 8'd1;
                end
                CMD_MINUS: begin
                    tape_img[s][p] = (cell_val == 0) ? cell_max_img : cell_val - 8'd1;
                end
                CMD_DOT: begin
                    r.out_valid = 1'b1;
                    r.out_char = cell_val;
                end
                CMD_COMMA: begin
                    if (w.in_value[31]) tape_img[s][p] = 8'd0;
                    else if (w.in_value[30:0] > 31'(cell_max_img)) tape_img[s][p] = cell_max_img;
                    else tape_img[s][p] = w.in_value[7:0];
                end
                CMD_OPEN: begin
                    if (cell_val == 0) begin
                        skip_img[s] = 1;
                    end else if (nest_img[s] >= STACK_DEPTH) begin
                        err = ERR_OVERFLOW;
                    end else begin
                        stack_img[s][nest_img[s]] = w.addr;
                        nest_img[s]++;
                    end
                end
                CMD_CLOSE: begin
                    if (nest_img[s] == 0) begin
                        err = ERR_UNDERFLOW;
                    end else if (cell_val == 0) begin
                        nest_img[s]--;
                    end else begin
                        r.next_addr = stack_img[s][nest_img[s] - 1] + ADDR_BITS'(1);
                        r.jumped = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        r.skipping = (skip_img[s] != 0);
        r.error = err;
        return r;
    endfunction

    // Queue one word, advance the planning copy and return the next address
    function automatic logic [15:0] plan_word(input logic [7:0] c, input logic [15:0] a,
                                              input logic [31:0] v);
        bfeu_in_t  w;
        bfeu_out_t r;
        w.cmd = c;
        w.addr = a;
        w.in_value = v;
        r = execute_char(PLAN, w);
        program_words.push_back(w);
        words_queued++;
        return r.next_addr;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        else if (r < 92) return $urandom_range(1, 3);
        else return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_addr();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return {1'b1, 31'($urandom)};
            2: return $urandom_range(0, 300);
            3: return 32'(cell_max_img) + $urandom_range(0, 2) - 1;
            default: return $urandom_range(0, 20);
        endcase
    endfunction

    // Any byte but a bracket
    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CMD_OPEN || c == CMD_CLOSE) c = 8'h00;
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (fail_count < REPORT_CAP)
            $display("[%0t] result %0d: %s expected 0x%0h got 0x%0h",
                     $time, results_seen, what, want, got);
        fail_count++;
    endtask

    task automatic check_result(input bfeu_out_t got);
        bfeu_out_t want;
        if (due_results.size() == 0) begin
            report_mismatch("word with nothing outstanding", 0, 32'(got));
        end else begin
            want = due_results.pop_front();
            if (got.next_addr !== want.next_addr)
                report_mismatch("next_addr", 32'(want.next_addr), 32'(got.next_addr));
            if (got.jumped !== want.jumped)
                report_mismatch("jumped", 32'(want.jumped), 32'(got.jumped));
            if (got.out_valid !== want.out_valid)
                report_mismatch("out_valid", 32'(want.out_valid), 32'(got.out_valid));
            if (got.out_char !== want.out_char)
                report_mismatch("out_char", 32'(want.out_char), 32'(got.out_char));
            if (got.skipping !== want.skipping)
                report_mismatch("skipping", 32'(want.skipping), 32'(got.skipping));
            if (got.error !== want.error)
                report_mismatch("error", 32'(want.error), 32'(got.error));
            if (want.jumped) jumps_seen++;
            if (want.out_valid) dots_seen++;
            if (want.skipping) skips_seen++;
            if (want.error == ERR_OVERFLOW) overflows_seen++;
            if (want.error == ERR_UNDERFLOW) underflows_seen++;
        end
    endtask

    // Driver: launch queued words, hold each until taken, then maybe idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                due_results.push_back(execute_char(LIVE, s_data));
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (program_words.size() != 0) begin
                    next_word = program_words.pop_front();
                    s_data <= next_word;
                    s_valid <= 1'b1;
                    send_gap <= calm ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result word, stall the result side at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                check_result(m_data);
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                hold_left <= calm ? 0 : pick_gap();
            end
        end
    end

    // Hold until every queued word has produced its result
    task automatic wait_drained();
        do @(posedge aclk); while (results_seen < words_queued);
    endtask

    task automatic set_cell_max(input logic [7:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cell_max_img = v;
        cfg_writes++;
    endtask

    // Feed brackets and noise until the planned state leaves skip mode
    task automatic leave_skip();
        while (skip_img[PLAN] != 0) begin
            if ($urandom_range(0, 1) != 0) void'(plan_word(CMD_CLOSE, rand_addr(), rand_value()));
            else void'(plan_word(noise_char(), rand_addr(), rand_value()));
        end
    endtask

    // Random program text with mostly balanced brackets, some noise and strays
    task automatic build_program(input int len);
        int i;
        int r;
        int open_cnt;
        prog_text.delete();
        open_cnt = 0;
        for (i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 20) prog_text.push_back(CMD_PLUS);
            else if (r < 30) prog_text.push_back(CMD_MINUS);
            else if (r < 40) prog_text.push_back(CMD_RIGHT);
            else if (r < 50) prog_text.push_back(CMD_LEFT);
            else if (r < 58) prog_text.push_back(CMD_DOT);
            else if (r < 64) prog_text.push_back(CMD_COMMA);
            else if (r < 76) begin
                prog_text.push_back(CMD_OPEN);
                open_cnt++;
            end else if (r < 90) begin
                if (open_cnt > 0) begin
                    prog_text.push_back(CMD_CLOSE);
                    open_cnt--;
                end else begin
                    prog_text.push_back(CMD_MINUS);
                end
            end else if (r < 95) prog_text.push_back(noise_char());
            else if (r < 97) prog_text.push_back(CMD_CLOSE);
            else prog_text.push_back(CMD_MINUS);
        end
        while (open_cnt > 0) begin
            prog_text.push_back(CMD_CLOSE);
            open_cnt--;
        end
    endtask

    // Follow the program along the planned next addresses, as a fetch unit would
    task automatic run_program(input logic [15:0] base, input int max_steps);
        logic [15:0] pc;
        logic [15:0] off;
        int          steps;
        pc = base;
        off = '0;
        steps = 0;
        while (int'(off) < prog_text.size() && steps < max_steps) begin
            pc = plan_word(prog_text[off], pc, rand_value());
            off = pc - base;
            steps++;
        end
    endtask

    task automatic run_programs(input int count);
        int i;
        logic [15:0] base;
        for (i = 0; i < count; i++) begin
            build_program($urandom_range(4, 24));
            if ($urandom_range(0, 9) == 0) base = 16'($urandom_range(16'hFFF0, 16'hFFFF));
            else base = rand_addr();
            run_program(base, 80);
        end
    endtask

    // Fill the loop stack past its depth, then unwind it past empty
    task automatic plan_deep_nesting();
        int i;
        int n;
        leave_skip();
        void'(plan_word(CMD_COMMA, rand_addr(), 32'd1));
        for (i = 0; i < STACK_DEPTH + 2; i++)
            void'(plan_word(CMD_OPEN, rand_addr(), rand_value()));
        void'(plan_word(CMD_CLOSE, rand_addr(), rand_value()));
        void'(plan_word(CMD_COMMA, rand_addr(), 32'd0));
        n = nest_img[PLAN] + 2;
        for (i = 0; i < n; i++)
            void'(plan_word(CMD_CLOSE, rand_addr(), rand_value()));
    endtask

    // Open brackets on a zero cell deep enough to saturate the skip depth
    task automatic plan_deep_skip();
        int opens;
        leave_skip();
        void'(plan_word(CMD_COMMA, rand_addr(), 32'd0));
        opens = 0;
        while (opens < int'(SKIP_MAX) + 4) begin
            if ($urandom_range(0, 3) != 0) begin
                void'(plan_word(CMD_OPEN, rand_addr(), rand_value()));
                opens++;
            end else begin
                void'(plan_word(noise_char(), rand_addr(), rand_value()));
            end
        end
        leave_skip();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Edge cases at the reset value of cell_max
        void'(plan_word(CMD_PLUS, 16'h0000, 32'd0));
        void'(plan_word(CMD_MINUS, 16'h0001, 32'd0));
        void'(plan_word(CMD_MINUS, 16'h0002, 32'd0));
        void'(plan_word(CMD_PLUS, 16'h0003, 32'd0));
        void'(plan_word(CMD_COMMA, 16'h0004, 32'h7FFF_FFFF));
        void'(plan_word(CMD_DOT, 16'h0005, 32'd0));
        void'(plan_word(CMD_COMMA, 16'h0006, 32'h8000_0000));
        void'(plan_word(CMD_COMMA, 16'h0007, 32'd128));
        void'(plan_word(CMD_COMMA, 16'h0008, 32'd127));
        void'(plan_word(CMD_COMMA, 16'h0009, 32'd55));
        void'(plan_word(CMD_DOT, 16'h000A, 32'd0));
        void'(plan_word(CMD_LEFT, 16'h000B, 32'd0));
        void'(plan_word(CMD_DOT, 16'h000C, 32'd0));
        void'(plan_word(CMD_RIGHT, 16'h000D, 32'd0));
        void'(plan_word(CMD_CLOSE, 16'h000E, 32'd0));
        void'(plan_word(CMD_OPEN, 16'hFFFF, 32'd0));
        void'(plan_word(CMD_CLOSE, 16'h0000, 32'hFFFF_FFFF));
        void'(plan_word(CMD_COMMA, 16'h0001, -32'sd5));
        void'(plan_word(CMD_CLOSE, 16'h0002, 32'd0));
        void'(plan_word(CMD_OPEN, 16'h0003, 32'd0));
        void'(plan_word(CMD_PLUS, 16'h0004, 32'd0));
        void'(plan_word(8'h00, 16'h0005, 32'd0));
        void'(plan_word(CMD_OPEN, 16'h0006, 32'd0));
        void'(plan_word(CMD_CLOSE, 16'h0007, 32'd0));
        void'(plan_word(CMD_CLOSE, 16'h0008, 32'd0));
        void'(plan_word(8'hFF, 16'h0009, 32'd0));
        void'(plan_word(CMD_DOT, 16'h8000, 32'd0));
        wait_drained();

        // Widest range, no idling on either side
        set_cell_max(8'd255);
        calm = 1'b1;
        void'(plan_word(CMD_COMMA, rand_addr(), 32'd300));
        void'(plan_word(CMD_DOT, rand_addr(), 32'd0));
        void'(plan_word(CMD_PLUS, rand_addr(), 32'd0));
        run_programs(4);
        // leave cells above the next, lower maximum
        leave_skip();
        void'(plan_word(CMD_COMMA, rand_addr(), 32'd250));
        void'(plan_word(CMD_RIGHT, rand_addr(), 32'd0));
        void'(plan_word(CMD_COMMA, rand_addr(), 32'd251));
        void'(plan_word(CMD_LEFT, rand_addr(), 32'd0));
        wait_drained();

        // Narrowest useful range over cells that exceed it
        set_cell_max(8'd1);
        calm = 1'b0;
        void'(plan_word(CMD_PLUS, rand_addr(), 32'd0));
        void'(plan_word(CMD_RIGHT, rand_addr(), 32'd0));
        void'(plan_word(CMD_MINUS, rand_addr(), 32'd0));
        void'(plan_word(CMD_DOT, rand_addr(), 32'd0));
        void'(plan_word(CMD_LEFT, rand_addr(), 32'd0));
        run_programs(4);
        wait_drained();

        // Zero maximum: plus, minus and comma all leave zero
        set_cell_max(8'd0);
        leave_skip();
        void'(plan_word(CMD_PLUS, rand_addr(), 32'd0));
        void'(plan_word(CMD_MINUS, rand_addr(), 32'd0));
        void'(plan_word(CMD_COMMA, rand_addr(), 32'd9));
        void'(plan_word(CMD_DOT, rand_addr(), 32'd0));
        void'(plan_word(CMD_OPEN, rand_addr(), 32'd0));
        void'(plan_word(CMD_CLOSE, rand_addr(), 32'd0));
        run_programs(3);
        wait_drained();

        set_cell_max(8'd200);
        plan_deep_nesting();
        run_programs(3);
        wait_drained();

        set_cell_max(8'($urandom_range(1, 255)));
        plan_deep_skip();
        wait_drained();

        // Random programs, changing the maximum now and then
        while (words_queued < 1230) begin
            if ($urandom_range(0, 2) == 0) set_cell_max(8'($urandom_range(1, 255)));
            calm = ($urandom_range(0, 5) == 0);
            run_programs(6);
            wait_drained();
        end

        calm = 1'b0;
        repeat (8) @(posedge aclk);
        if (due_results.size() != 0)
            report_mismatch("results never returned", 0, due_results.size());

        $display("ran %0d words over %0d cell_max writes: %0d jumps, %0d dots, %0d skip words",
                 words_queued, cfg_writes, jumps_seen, dots_seen, skips_seen);
        $display("loop stack overflows %0d, underflows %0d, mismatches %0d",
                 overflows_seen, underflows_seen, fail_count);
        if (fail_count == 0) begin
            $display("brainfuck_execution_unit regression: pass");
        end else begin
            $display("brainfuck_execution_unit regression: fail");
        end
        $finish;
    end

    // Backstop: covers the tape clearing pass and the slowest idling pattern
    initial begin
        #3_000_000;
        $display("brainfuck_execution_unit regression: fail");
        $finish;
    end

endmodule
